>>> src/min_time_refuel_stop_dp_unit_assert.svh
// assertion macros for the refuel stop dp unit
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef MIN_TIME_REFUEL_STOP_DP_UNIT_ASSERT_SVH
`define MIN_TIME_REFUEL_STOP_DP_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MTRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MTRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mtrs_pkg.sv
// shared constants and control structs of the refuel stop dp unit
// no dependencies
package mtrs_pkg;

    localparam int MTRS_MAX_POINTS_DEF = 128;

    localparam int DIST_W = 16;
    localparam int STOP_W = 16;
    localparam int COST_W = 24;
    localparam int PRED_W = 8;

    localparam logic [COST_W-1:0] COST_MAX      = '1;
    localparam logic [DIST_W-1:0] MAX_RANGE_RST = '1;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_RANGE = 2'd0;

    // control part of the search word walking down the chain
    typedef struct packed {
        logic valid;
        logic found;
        logic last;
        logic full;
    } t_tok_ctl;

    // store write command broadcast to the cells
    typedef struct packed {
        logic en;
        logic live;
    } t_wr_ctl;

endpackage

>>> src/mtrs_cell.sv
// one cell of the chain: holds one stored route point and tests it
// against the search word passing by; depends on mtrs_pkg
module mtrs_cell import mtrs_pkg::*; #(
    parameter int MAX_POINTS = MTRS_MAX_POINTS_DEF,
    parameter int CELL_IDX   = 1,
    localparam int IdxW      = $clog2(MAX_POINTS + 1),
    localparam int PosW      = DIST_W + IdxW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [DIST_W-1:0] i_max_range,
    input  logic [IdxW-1:0]   i_pi,
    input  t_wr_ctl           i_wr,
    input  logic [IdxW-1:0]   i_wr_idx,
    input  logic [PosW-1:0]   i_wr_pos,
    input  logic [COST_W-1:0] i_wr_cost,
    input  t_tok_ctl          i_ctl,
    input  logic [PosW-1:0]   i_here,
    input  logic [STOP_W-1:0] i_stop,
    input  logic [COST_W-1:0] i_best,
    input  logic [IdxW-1:0]   i_pred,
    output t_tok_ctl          o_ctl,
    output logic [PosW-1:0]   o_here,
    output logic [STOP_W-1:0] o_stop,
    output logic [COST_W-1:0] o_best,
    output logic [IdxW-1:0]   o_pred
);

    localparam logic [IdxW-1:0] CellIdx = IdxW'(CELL_IDX);

    // stored point
    logic [PosW-1:0]   r_pos;
    logic [COST_W-1:0] r_cost;
    logic              r_live;

    // search word register
    t_tok_ctl          r_ctl,  n_ctl;
    logic [PosW-1:0]   r_here;
    logic [STOP_W-1:0] r_stop;
    logic [COST_W-1:0] r_best, n_best;
    logic [IdxW-1:0]   r_pred, n_pred;

    logic [PosW-1:0]   span;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] cand;
    logic              consider;
    logic              take;
    logic              wr_hit;

    always_comb begin
        span     = i_here - r_pos;
        sum      = {1'b0, r_cost} + (COST_W+1)'(i_stop);
        cand     = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        consider = i_ctl.valid && !i_ctl.full && r_live && (CellIdx <= i_pi)
                   && (span <= PosW'(i_max_range));
        take     = consider && (!i_ctl.found || (cand < i_best));
        n_best   = take ? cand : i_best;
        n_pred   = take ? CellIdx : i_pred;
        n_ctl       = i_ctl;
        n_ctl.found = i_ctl.found || take;
    end

    assign wr_hit = i_wr.en && (i_wr_idx == CellIdx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_live <= 1'b0;
        end else begin
            if (i_adv) begin
                r_ctl <= n_ctl;
            end
            if (wr_hit) begin
                r_live <= i_wr.live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_here <= i_here;
            r_stop <= i_stop;
            r_best <= n_best;
            r_pred <= n_pred;
        end
        if (wr_hit) begin
            r_pos  <= i_wr_pos;
            r_cost <= i_wr_cost;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_here = r_here;
    assign o_stop = r_stop;
    assign o_best = r_best;
    assign o_pred = r_pred;

endmodule

>>> src/min_time_refuel_stop_dp_unit.sv
// top level of the minimum-time refuel stop planner
// depends on mtrs_pkg, mtrs_cell and the assertion macro header
//
// usage:
//   input channel (i_in_valid / o_in_stall) takes one route point per word:
//   segment distance, stop time and a last-point mark. output channel
//   (o_out_valid / i_out_stall) gives one word per point: best cost,
//   predecessor index, reachable flag and route end.
//   each point launches a search word into a chain of MAX_POINTS cells, one
//   cell per stored point; the word moves one cell per cycle while the
//   chain is not frozen, and its result is registered at the chain end.
//   one point is in flight at a time and the next is taken the cycle after
//   the result leaves the chain. the result waits in an output register,
//   so a new point is taken while the receiver still stalls the previous
//   result; a stalled result at the chain end freezes the chain until the
//   register frees. the destination ends the route and the next point
//   starts a new one. reset empties the chain and output, starts a fresh
//   route and sets max_range to 65535; no clearing pass is needed.
//   the user must write max_range over the apb port only while the block
//   is idle; the block itself does not enforce this.

`include "min_time_refuel_stop_dp_unit_assert.svh"

module min_time_refuel_stop_dp_unit import mtrs_pkg::*; #(
    parameter int MAX_POINTS = MTRS_MAX_POINTS_DEF,
    localparam int IdxW      = $clog2(MAX_POINTS + 1),
    localparam int PosW      = DIST_W + IdxW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // point input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DIST_W-1:0]     i_segment_distance,
    input  logic [STOP_W-1:0]     i_stop_time,
    input  logic                  i_last_point,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COST_W-1:0]     o_best_cost,
    output logic [PRED_W-1:0]     o_predecessor,
    output logic                  o_reachable,
    output logic                  o_route_end
);

    localparam logic [IdxW-1:0] MaxIdx = IdxW'(MAX_POINTS);

    // config register
    logic [DIST_W-1:0] r_max_range;
    logic              cfg_wr;

    // route state
    logic              r_busy;
    logic [IdxW-1:0]   r_pi;
    logic [PosW-1:0]   r_last_pos;

    // output register
    logic              r_out_valid;
    logic [COST_W-1:0] r_out_cost;
    logic [PRED_W-1:0] r_out_pred;
    logic              r_out_reach;
    logic              r_out_end;

    // chain links: link 0 is the entry, link k the output of cell k
    t_tok_ctl          link_ctl  [MAX_POINTS+1];
    logic [PosW-1:0]   link_here [MAX_POINTS+1];
    logic [STOP_W-1:0] link_stop [MAX_POINTS+1];
    logic [COST_W-1:0] link_best [MAX_POINTS+1];
    logic [IdxW-1:0]   link_pred [MAX_POINTS+1];

    logic              accept;
    logic              adv;
    logic              retire;
    logic              full;
    logic              origin_ok;
    logic [PosW-1:0]   entry_here;
    logic [STOP_W-1:0] entry_stop;
    t_tok_ctl          end_ctl;
    logic [PosW-1:0]   end_here;
    logic [COST_W-1:0] end_best;
    logic [IdxW-1:0]   end_pred;

    t_wr_ctl           wr;
    logic [IdxW-1:0]   wr_idx;
    logic [COST_W-1:0] wr_cost;

    // apb: single register, pready tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_RANGE);

    always_comb begin
        prdata = '0;
        unique case (paddr)
            ADDR_MAX_RANGE: prdata = APB_DATA_W'(r_max_range);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAX_RANGE_RST;
        end else if (cfg_wr) begin
            r_max_range <= pwdata[DIST_W-1:0];
        end
    end

    // one point in flight: take a word only while the chain is empty
    assign o_in_stall = r_busy;
    assign accept     = i_in_valid && !r_busy;

    // entry word: the origin candidate is settled here, cells handle the rest
    always_comb begin
        full       = (r_pi == MaxIdx);
        entry_here = r_last_pos + PosW'(i_segment_distance);
        entry_stop = i_last_point ? '0 : i_stop_time;
        // the origin sits at position 0, so its distance is the position itself
        origin_ok  = !full && (entry_here <= PosW'(r_max_range));

        link_ctl[0].valid  = accept;
        link_ctl[0].found  = origin_ok;
        link_ctl[0].last   = i_last_point;
        link_ctl[0].full   = full;
        link_here[0]       = entry_here;
        link_stop[0]       = entry_stop;
        link_best[0]       = origin_ok ? COST_W'(entry_stop) : '0;
        link_pred[0]       = '0;
    end

    // chain end and stall
    assign end_ctl  = link_ctl[MAX_POINTS];
    assign end_here = link_here[MAX_POINTS];
    assign end_best = link_best[MAX_POINTS];
    assign end_pred = link_pred[MAX_POINTS];

    // freeze the chain while a finished word cannot move to the output
    assign adv    = !(end_ctl.valid && r_out_valid && i_out_stall);
    assign retire = end_ctl.valid && adv;

    // store the new point in cell pi+1 unless the route is already full
    always_comb begin
        wr.en   = retire && !end_ctl.full;
        wr.live = end_ctl.found;
        wr_idx  = r_pi + 1'b1;
        wr_cost = end_ctl.found ? end_best : '0;
    end

    for (genvar k = 1; k <= MAX_POINTS; k++) begin : g_cell
        mtrs_cell #(
            .MAX_POINTS (MAX_POINTS),
            .CELL_IDX   (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (adv),
            .i_max_range (r_max_range),
            .i_pi        (r_pi),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx),
            .i_wr_pos    (end_here),
            .i_wr_cost   (wr_cost),
            .i_ctl       (link_ctl[k-1]),
            .i_here      (link_here[k-1]),
            .i_stop      (link_stop[k-1]),
            .i_best      (link_best[k-1]),
            .i_pred      (link_pred[k-1]),
            .o_ctl       (link_ctl[k]),
            .o_here      (link_here[k]),
            .o_stop      (link_stop[k]),
            .o_best      (link_best[k]),
            .o_pred      (link_pred[k])
        );
    end

    // route bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pi       <= '0;
            r_last_pos <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (retire) begin
                r_busy <= 1'b0;
            end
            if (retire) begin
                if (end_ctl.last) begin
                    // destination: next word starts a new route
                    r_pi       <= '0;
                    r_last_pos <= '0;
                end else if (!end_ctl.full) begin
                    r_pi       <= wr_idx;
                    r_last_pos <= end_here;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (retire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_cost  <= end_ctl.found ? end_best : '0;
            r_out_pred  <= end_ctl.found ? PRED_W'(end_pred) : '0;
            r_out_reach <= end_ctl.found;
            r_out_end   <= end_ctl.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_best_cost   = r_out_cost;
    assign o_predecessor = r_out_pred;
    assign o_reachable   = r_out_reach;
    assign o_route_end   = r_out_end;

    // checks
    `MTRS_ASSERT_NXT(a_retire_frees, retire, !r_busy && o_out_valid, "chain not freed on retire")
    `MTRS_ASSERT_IMP(a_unreach_zero, o_out_valid && !o_reachable,
        o_best_cost == '0 && o_predecessor == '0, "unreachable result carries data")
    `MTRS_ASSERT_IMP(a_pi_bound, 1'b1, r_pi <= MaxIdx, "point index past store depth")
    `MTRS_ASSERT_NXT(a_end_hold, end_ctl.valid && !adv,
        end_ctl.valid && $stable(end_best) && $stable(end_pred), "stalled chain end moved")
    `MTRS_ASSERT_IMP(a_word_busy, end_ctl.valid, r_busy, "word in chain while idle")

endmodule
